// ----- design/mbet_pkg.sv -----
// Shared types and constants for the Mandelbrot escape-time pixel block.
// No dependencies; imported by mbet_ring, mandelbrot_escape_time_pixel, mbet_checker and tb_top.
`default_nettype none

package mbet_pkg;

  // Field widths fixed by the interface
  localparam int COL_W     = 10;
  localparam int PITCH_W   = 28;
  localparam int INT_W     = 8;
  localparam int CFG_IDX_W = 2;

  // (col - center) * pitch, exact
  localparam int PROD_W = COL_W + 1 + PITCH_W;

  // Order tags: the ring holds at most four requests, so three bits keep them apart
  localparam int TAG_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CCOL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CROW  = 2'd2;

  // Register reset values
  localparam logic [PITCH_W-1:0] PITCH_RST = 28'd894785;
  localparam logic [COL_W-1:0]   CCOL_RST  = 10'd600;
  localparam logic [COL_W-1:0]   CROW_RST  = 10'd300;

  typedef logic [TAG_W-1:0] tag_t;

  // Status of the request sitting at the ring tail
  typedef struct packed {
    logic             vld;
    logic             done;
    tag_t             tag;
    logic [INT_W-1:0] ity;
  } tail_t;

endpackage

`default_nettype wire

// ----- design/mandelbrot_escape_time_pixel.sv -----
// Mandelbrot escape-time pixel: each request passes two front stages, waits in the second
// for a free ring slot, makes one ring pass per iteration until it stops after n iterations
// (n <= MAX_ITER), then waits for older pixels to leave in order.
// Up to four pixels share the 4-stage iteration ring, one iteration per pass, so a new
// pixel can enter the ring before an earlier one has finished.
// Synchronous reset loads pitch 894785, center 600/300 and empties all stages.
// Depends on mbet_pkg and mbet_ring.
`default_nettype none

module mandelbrot_escape_time_pixel #(
  parameter int MAX_ITER   = 100,
  parameter int EARLY_ITER = 20,
  parameter int FRAC_BITS  = 28
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Configuration
  input  wire logic                           cfg_we,
  input  wire logic [mbet_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [mbet_pkg::PITCH_W-1:0]   cfg_wdata,
  // Pixel requests
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [mbet_pkg::COL_W-1:0]     in_col,
  input  wire logic [mbet_pkg::COL_W-1:0]     in_row,
  // Results
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [mbet_pkg::INT_W-1:0]          out_intensity
);
  import mbet_pkg::*;

  localparam int W  = FRAC_BITS + 4;
  localparam int CW = (W > PROD_W) ? W : PROD_W;
  localparam logic signed [CW-1:0] CMAX = CW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [CW-1:0] CMIN = ~CMAX;

  // Clamp the pixel offset times pitch to W bits
  function automatic logic signed [W-1:0] sat_c(input logic signed [PROD_W-1:0] p);
    logic signed [CW-1:0] e;
    e = CW'(p);
    if (e > CMAX) begin
      return W'(CMAX);
    end
    if (e < CMIN) begin
      return W'(CMIN);
    end
    return W'(e);
  endfunction

  logic [PITCH_W-1:0] pitch_r;
  logic [COL_W-1:0]   ccol_r, crow_r;

  logic                     f1_vld_r, f2_vld_r;
  logic signed [COL_W:0]    f1_dc_r, f1_dr_r;
  logic signed [PROD_W-1:0] f2_pre_r, f2_pim_r;
  logic                     in_acc, f1_move, f2_move, ring_free, take;
  tag_t                     ent_tag_r, head_r;
  tail_t                    tail;
  logic                     out_vld_r;
  logic [INT_W-1:0]         out_ity_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= PITCH_RST;
      ccol_r  <= CCOL_RST;
      crow_r  <= CROW_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PITCH: pitch_r <= cfg_wdata;
        CFG_CCOL:  ccol_r  <= cfg_wdata[COL_W-1:0];
        CFG_CROW:  crow_r  <= cfg_wdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage advance
  always_comb begin
    take      = tail.vld && tail.done && (tail.tag == head_r) && (!out_vld_r || !out_stall);
    ring_free = !tail.vld || take;
    f2_move   = f2_vld_r && ring_free;
    f1_move   = f1_vld_r && (!f2_vld_r || f2_move);
    in_stall  = f1_vld_r && !(!f2_vld_r || f2_move);
    in_acc    = in_valid && !in_stall;
  end

  // Front stage 1: pixel offsets from center
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= in_acc || (f1_vld_r && !f1_move);
    end
    if (in_acc) begin
      f1_dc_r <= $signed({1'b0, in_col}) - $signed({1'b0, ccol_r});
      f1_dr_r <= $signed({1'b0, in_row}) - $signed({1'b0, crow_r});
    end
  end

  // Front stage 2: scale by pitch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else begin
      f2_vld_r <= f1_move || (f2_vld_r && !f2_move);
    end
    if (f1_move) begin
      f2_pre_r <= PROD_W'(f1_dc_r) * PROD_W'($signed({1'b0, pitch_r}));
      f2_pim_r <= PROD_W'(f1_dr_r) * PROD_W'($signed({1'b0, pitch_r}));
    end
  end

  // Order tags: issue on ring entry, retire in the same order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_tag_r <= '0;
      head_r    <= '0;
    end else begin
      if (f2_move) begin
        ent_tag_r <= ent_tag_r + TAG_W'(1);
      end
      if (take) begin
        head_r <= head_r + TAG_W'(1);
      end
    end
  end

  mbet_ring #(
    .MAX_ITER   (MAX_ITER),
    .EARLY_ITER (EARLY_ITER),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ent_vld (f2_move),
    .ent_tag (ent_tag_r),
    .ent_re  (sat_c(f2_pre_r)),
    .ent_im  (sat_c(f2_pim_r)),
    .take    (take),
    .tail    (tail)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= take || (out_vld_r && out_stall);
    end
    if (take) begin
      out_ity_r <= tail.ity;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_intensity = out_ity_r;

endmodule

`default_nettype wire

// ----- design/mbet_ring.sv -----
// Four-stage recirculating iteration pipeline: one z = z^2 + c step per pass.
// Depends on mbet_pkg (tag_t, tail_t, INT_W).
`default_nettype none

module mbet_ring #(
  parameter int MAX_ITER   = 100,
  parameter int EARLY_ITER = 20,
  parameter int FRAC_BITS  = 28
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      ent_vld,
  input  wire mbet_pkg::tag_t            ent_tag,
  input  wire logic signed [FRAC_BITS+3:0] ent_re,
  input  wire logic signed [FRAC_BITS+3:0] ent_im,
  input  wire logic                      take,
  output mbet_pkg::tail_t                tail
);
  import mbet_pkg::*;

  localparam int W  = FRAC_BITS + 4;
  localparam int W1 = W + 1;
  localparam int PW = 2 * W;
  localparam int KW = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = ~VMAX;
  localparam logic signed [W-1:0] TWO  = W'(64'd2 << FRAC_BITS);
  localparam logic signed [W-1:0] HUND = W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [KW-1:0]       K_LAST = KW'(MAX_ITER - 1);

  // Per-request bookkeeping that travels around the ring
  typedef struct packed {
    logic                vld;
    logic                done;
    tag_t                tag;
    logic [KW-1:0]       k;
    logic [INT_W-1:0]    ity;
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
  } slot_t;

  // Clamp a W+1 bit sum to W bits
  function automatic logic signed [W-1:0] sat_w(input logic signed [W1-1:0] v);
    if (v[W1-1] != v[W-1]) begin
      return v[W1-1] ? VMIN : VMAX;
    end
    return v[W-1:0];
  endfunction

  // Arithmetic shift of an exact product, then clamp to W bits
  function automatic logic signed [W-1:0] msh(input logic signed [PW-1:0] p,
                                              input int sh);
    logic signed [PW-1:0] q;
    logic                 fits;
    q    = p >>> sh;
    fits = (&q[PW-1:W-1]) || !(|q[PW-1:W-1]);
    if (!fits) begin
      return q[PW-1] ? VMIN : VMAX;
    end
    return q[W-1:0];
  endfunction

  slot_t s1_r, s1_nxt, s2_r, s3_r, s4_r, s4_nxt;
  logic signed [W-1:0]  in_a, in_b;
  logic signed [PW-1:0] s1_aa_r, s1_bb_r, s1_ab_r;
  logic signed [W-1:0]  s2_na_r, s2_nb_r, s2_na_nxt, s2_nb_nxt;
  logic signed [PW-1:0] s3_pa_r, s3_pb_r;
  logic signed [W-1:0]  s3_na_r, s3_nb_r;
  logic signed [W-1:0]  s4_a_r, s4_b_r;
  logic signed [W-1:0]  mag;

  // Entry: a new request takes the slot, otherwise the tail recirculates
  always_comb begin
    s1_nxt = s4_r;
    in_a   = s4_a_r;
    in_b   = s4_b_r;
    if (ent_vld) begin
      s1_nxt.vld  = 1'b1;
      s1_nxt.done = 1'b0;
      s1_nxt.tag  = ent_tag;
      s1_nxt.k    = '0;
      s1_nxt.ity  = '0;
      s1_nxt.re   = ent_re;
      s1_nxt.im   = ent_im;
      in_a        = '0;
      in_b        = '0;
    end else begin
      s1_nxt.vld = s4_r.vld && !take;
    end
  end

  // Stage 1: squares and cross product of z
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
    end
    s1_aa_r <= PW'(in_a) * PW'(in_a);
    s1_bb_r <= PW'(in_b) * PW'(in_b);
    s1_ab_r <= PW'(in_a) * PW'(in_b);
  end

  // Stage 2: new z
  always_comb begin
    s2_na_nxt = sat_w(W1'(sat_w(W1'(msh(s1_aa_r, FRAC_BITS)) - W1'(msh(s1_bb_r, FRAC_BITS))))
                      + W1'(s1_r.re));
    s2_nb_nxt = sat_w(W1'(msh(s1_ab_r, FRAC_BITS - 1)) + W1'(s1_r.im));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
    end else begin
      s2_r <= s1_r;
    end
    s2_na_r <= s2_na_nxt;
    s2_nb_r <= s2_nb_nxt;
  end

  // Stage 3: squares of the new z
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.vld <= 1'b0;
    end else begin
      s3_r <= s2_r;
    end
    s3_pa_r <= PW'(s2_na_r) * PW'(s2_na_r);
    s3_pb_r <= PW'(s2_nb_r) * PW'(s2_nb_r);
    s3_na_r <= s2_na_r;
    s3_nb_r <= s2_nb_r;
  end

  // Stage 4: magnitude, escape, early-exit and last-iteration tests
  always_comb begin
    mag    = sat_w(W1'(msh(s3_pa_r, FRAC_BITS)) + W1'(msh(s3_pb_r, FRAC_BITS)));
    s4_nxt = s3_r;
    if (!s3_r.done) begin
      if (mag > TWO) begin
        s4_nxt.done = 1'b1;
        s4_nxt.ity  = 8'd255 - (INT_W'(s3_r.k) << 2);
      end else if ((mag < HUND) && (32'(s3_r.k) < EARLY_ITER)) begin
        s4_nxt.done = 1'b1;
        s4_nxt.ity  = '0;
      end else if (s3_r.k == K_LAST) begin
        s4_nxt.done = 1'b1;
        s4_nxt.ity  = '0;
      end else begin
        s4_nxt.k = s3_r.k + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.vld <= 1'b0;
    end else begin
      s4_r <= s4_nxt;
    end
    s4_a_r <= s3_na_r;
    s4_b_r <= s3_nb_r;
  end

  assign tail.vld  = s4_r.vld;
  assign tail.done = s4_r.done;
  assign tail.tag  = s4_r.tag;
  assign tail.ity  = s4_r.ity;

endmodule

`default_nettype wire

// ----- sim/mbet_checker.sv -----
// Checker for the Mandelbrot escape-time pixel block: watches the register port and both
// channels, predicts each pixel's intensity and compares results in order.
// Depends on mbet_pkg for field widths, register indexes and reset values.
`default_nettype none

module mbet_checker #(
  parameter int MAX_ITER   = 100,
  parameter int EARLY_ITER = 20,
  parameter int FRAC_BITS  = 28
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mbet_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [mbet_pkg::PITCH_W-1:0]   cfg_wdata,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic [mbet_pkg::COL_W-1:0]     in_col,
  input  wire logic [mbet_pkg::COL_W-1:0]     in_row,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic [mbet_pkg::INT_W-1:0]     out_intensity,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  checked
);
  import mbet_pkg::*;

  localparam int    WORD_W    = FRAC_BITS + 4;
  localparam longint WORD_MAX = (longint'(1) <<< (WORD_W - 1)) - 1;
  localparam longint WORD_MIN = -WORD_MAX - 1;
  localparam longint TWO      = longint'(2) <<< FRAC_BITS;
  localparam longint HUNDREDTH = ((longint'(1) <<< FRAC_BITS) + 50) / 100;

  typedef struct {
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;
    logic [INT_W-1:0] intensity;
  } pixel_exp_t;

  // Local copy of the view registers
  logic [PITCH_W-1:0] pitch_q;
  logic [COL_W-1:0]   ccol_q;
  logic [COL_W-1:0]   crow_q;

  pixel_exp_t intensity_q[$];

  function automatic longint clamp_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // floor(p*q / 2^sh), saturated; operands are word-sized so the product is exact
  function automatic longint mul_floor(input longint p, input longint q, input int sh);
    longint prod;
    prod = p * q;
    return clamp_word(prod >>> sh);
  endfunction

  function automatic logic [INT_W-1:0] escape_intensity(input logic [COL_W-1:0] col,
                                                        input logic [COL_W-1:0] row);
    longint cx, cy, ox, oy, sp;
    longint re, im, a, b, na, nb, m;
    logic [INT_W-1:0] res;
    bit done;
    cx = col;
    cy = row;
    ox = ccol_q;
    oy = crow_q;
    sp = pitch_q;
    re = clamp_word((cx - ox) * sp);
    im = clamp_word((cy - oy) * sp);
    a = 0;
    b = 0;
    res = '0;
    done = 1'b0;
    for (int k = 0; k < MAX_ITER && !done; k++) begin
      na = clamp_word(clamp_word(mul_floor(a, a, FRAC_BITS) - mul_floor(b, b, FRAC_BITS)) + re);
      nb = clamp_word(mul_floor(a, b, FRAC_BITS - 1) + im);
      a = na;
      b = nb;
      m = clamp_word(mul_floor(a, a, FRAC_BITS) + mul_floor(b, b, FRAC_BITS));
      if (m > TWO) begin
        res = INT_W'(255 - 4 * k);
        done = 1'b1;
      end else if (m < HUNDREDTH && k < EARLY_ITER) begin
        done = 1'b1;
      end
    end
    return res;
  endfunction

  // Register shadow, prediction on each accepted request, in-order compare on each result
  always @(posedge clk) begin
    pixel_exp_t e;
    if (!rst_n) begin
      pitch_q    <= PITCH_RST;
      ccol_q     <= CCOL_RST;
      crow_q     <= CROW_RST;
      intensity_q.delete();
      fail_count <= 0;
      pending    <= 0;
      checked    <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_PITCH: pitch_q <= cfg_wdata;
          CFG_CCOL:  ccol_q  <= cfg_wdata[COL_W-1:0];
          CFG_CROW:  crow_q  <= cfg_wdata[COL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        e.col = in_col;
        e.row = in_row;
        e.intensity = escape_intensity(in_col, in_row);
        intensity_q.push_back(e);
      end
      if (out_valid && !out_stall) begin
        checked <= checked + 1;
        if (intensity_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual intensity %0d",
                   $time, out_intensity);
          fail_count <= fail_count + 1;
        end else begin
          e = intensity_q.pop_front();
          if (out_intensity !== e.intensity) begin
            $display("%0t: pixel (%0d,%0d) expected intensity %0d, actual %0d",
                     $time, e.col, e.row, e.intensity, out_intensity);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= intensity_q.size();
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench top for mandelbrot_escape_time_pixel: resets the block, writes view settings,
// sends directed and random pixel requests with random idling, and reports the verdict.
// Depends on mbet_pkg, the block itself and mbet_checker.
`default_nettype none

module tb_top;
  import mbet_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 450;
  localparam int NUM_PHASES = 8;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [PITCH_W-1:0]   cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [COL_W-1:0]     in_col;
  logic [COL_W-1:0]     in_row;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [INT_W-1:0]     out_intensity;

  int fail_count, pending, checked;
  int n_pixels, n_settings, idle_cycles, stall_left;
  bit tx_free, rx_free;
  logic [COL_W-1:0] view_col, view_row;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mandelbrot_escape_time_pixel u_top (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata,
    .in_valid, .in_stall, .in_col, .in_row,
    .out_valid, .out_stall, .out_intensity
  );

  mbet_checker u_chk (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata,
    .in_valid, .in_stall, .in_col, .in_row,
    .out_valid, .out_stall, .out_intensity,
    .fail_count, .pending, .checked
  );

  // Result side backpressure: runs of stall or ready, mostly short, a few long
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 4);
      out_stall  <= rx_free ? 1'b0 : ($urandom_range(0, 2) == 0);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Watchdog: cycles with no request, result or register write
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no progress for %0d cycles at %0t", IDLE_LIMIT, $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_free) return 0;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One pixel request; returns at the edge that accepts it
  task automatic send_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_col   <= col;
    in_row   <= row;
    do @(posedge clk); while (in_stall);
    n_pixels++;
  endtask

  // Hold off requests until every outstanding pixel has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PITCH_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_view(input logic [PITCH_W-1:0] pitch, input logic [PITCH_W-1:0] ccol,
                          input logic [PITCH_W-1:0] crow);
    wait_drained();
    write_reg(CFG_PITCH, pitch);
    write_reg(CFG_CCOL, ccol);
    write_reg(CFG_CROW, crow);
    if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, PITCH_W'($urandom));
    cfg_we <= 1'b0;
    view_col = ccol[COL_W-1:0];
    view_row = crow[COL_W-1:0];
    n_settings++;
  endtask

  initial begin
    int count;
    logic [COL_W-1:0] col, row;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_col    <= '0;
    in_row    <= '0;
    tx_free   = 1'b0;
    rx_free   = 1'b0;
    n_pixels  = 0;
    n_settings = 1;
    view_col  = CCOL_RST;
    view_row  = CROW_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset view, corners, origin, orbits that stay, cycle or escape late
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd600, 10'd300);     // origin, stops early near zero
    send_pixel(10'd300, 10'd300);     // c = -1, period two orbit hits zero
    send_pixel(10'd570, 10'd330);     // bounded, runs every iteration
    send_pixel(10'd676, 10'd300);     // just past the cusp, escapes late
    send_pixel(10'd1023, 10'd300);
    send_pixel(10'd150, 10'd300);

    // Write to the unused index must leave the view alone
    wait_drained();
    write_reg(CFG_UNUSED, 28'hFFF_FFFF);
    cfg_we <= 1'b0;
    send_pixel(10'd570, 10'd330);

    // Zero pitch maps every pixel to the origin
    set_view(28'd0, 28'd600, 28'd300);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);

    // Largest pitch, centers at zero: far pixels saturate
    set_view(28'hFFF_FFFF, 28'd0, 28'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1, 10'd0);

    // Centers at the top, with upper data bits set that must be dropped
    set_view(28'd894785, 28'hFFF_FFFF, 28'hABC_DFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);

    // Smallest nonzero pitch
    set_view(28'd1, 28'd512, 28'd511);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);

    // Random phases, each under its own view
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          set_view(PITCH_RST, CCOL_RST, CROW_RST);
          count = 220;
        end
        1: begin
          set_view(PITCH_W'($urandom_range(1 << 12, 1 << 20)), PITCH_W'($urandom),
                   PITCH_W'($urandom));
          count = 200;
        end
        2: begin
          set_view(PITCH_W'($urandom), PITCH_W'($urandom), PITCH_W'($urandom));
          count = 150;
        end
        3: begin
          set_view(28'hFFF_FFFF, 28'd1023, 28'd0);
          count = 50;
        end
        4: begin
          set_view(28'd1, 28'd0, 28'd1023);
          count = 50;
        end
        5: begin
          set_view(PITCH_RST >> $urandom_range(0, 4), PITCH_W'($urandom_range(400, 800)),
                   PITCH_W'($urandom_range(200, 400)));
          count = 200;
        end
        6: begin
          set_view(28'd0, PITCH_W'($urandom), PITCH_W'($urandom));
          count = 40;
        end
        default: begin
          set_view(PITCH_RST, CCOL_RST, CROW_RST);
          count = 240;
        end
      endcase
      // Stretches with no idling on either side
      tx_free = (ph == NUM_PHASES - 1) || ($urandom_range(0, 3) == 0);
      rx_free = (ph == NUM_PHASES - 1);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          col = view_col + COL_W'($urandom_range(0, 200)) - COL_W'(100);
          row = view_row + COL_W'($urandom_range(0, 200)) - COL_W'(100);
        end else begin
          col = COL_W'($urandom);
          row = COL_W'($urandom);
        end
        send_pixel(col, row);
        if ($urandom_range(0, 149) == 0) wait_drained();
      end
    end

    // Drain and let the block settle
    tx_free = 1'b0;
    rx_free = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d pixel requests over %0d view settings, %0d results compared.",
             n_pixels, n_settings, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
design/mbet_pkg.sv
design/mbet_ring.sv
design/mandelbrot_escape_time_pixel.sv
sim/mbet_checker.sv
sim/tb_top.sv
